// ----- rtl/baf_pkg.sv -----
// Shared types and constants of the 2D box-average filter.
// No dependencies.
package baf_pkg;

  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned ROW_POS_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CH_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS   = 2'd0,
    CFG_CHANNELS = 2'd1,
    CFG_ROW_ELEM = 2'd2
  } cfg_idx_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic line_rd;
    logic line_acc;
    logic write;
    logic hist_rd;
    logic hist_acc;
    logic div_step;
    logic load_out;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_lines;
    logic line_last;
    logic emit;
    logic hist_last;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

// ----- rtl/baf_in_if.sv -----
// Input word channel: valid/ready with sample and frame start.
// Depends on baf_pkg.
interface baf_in_if;
  logic                          valid;
  logic                          ready;
  logic [baf_pkg::SAMPLE_W-1:0]  sample;
  logic                          frame_start;
  modport source (output valid, output sample, output frame_start, input ready);
  modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

// ----- rtl/baf_out_if.sv -----
// Output word channel: valid/ready with average and row-last flag.
// Depends on baf_pkg.
interface baf_out_if;
  logic                          valid;
  logic                          ready;
  logic [baf_pkg::SAMPLE_W-1:0]  average;
  logic                          row_last;
  modport source (output valid, output average, output row_last, input ready);
  modport sink   (input valid, input average, input row_last, output ready);
endinterface

// ----- rtl/baf_ram.sv -----
// Generic single-port RAM, registered read.
// No dependencies.
module baf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/baf_ctrl.sv -----
// Sequencer of the box filter: steps one word through line reads,
// store write, column-sum taps, division and output. Depends on baf_pkg.
module baf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  baf_pkg::status_t  status_i,
  output baf_pkg::cmd_t     cmd_o
);
  import baf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LRA  = 8'b0000_0010,
    S_LRD  = 8'b0000_0100,
    S_WR   = 8'b0000_1000,
    S_HRA  = 8'b0001_0000,
    S_HRD  = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_LRA;
        end
      end
      S_LRA: begin
        if (status_i.need_lines) begin
          cmd_o.line_rd = 1'b1;
          state_d = S_LRD;
        end else begin
          state_d = S_WR;
        end
      end
      S_LRD: begin
        cmd_o.line_acc = 1'b1;
        state_d = status_i.line_last ? S_WR : S_LRA;
      end
      S_WR: begin
        cmd_o.write = 1'b1;
        state_d = status_i.emit ? S_HRA : S_IDLE;
      end
      S_HRA: begin
        cmd_o.hist_rd = 1'b1;
        state_d = S_HRD;
      end
      S_HRD: begin
        cmd_o.hist_acc = 1'b1;
        state_d = status_i.hist_last ? S_DIV : S_HRA;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_OUT;
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
endmodule

// ----- rtl/baf_datapath.sv -----
// Datapath of the box filter: config registers, positions, line store,
// column-sum history, accumulator, restoring divider, output register.
// Depends on baf_pkg and baf_ram.
module baf_datapath #(
  parameter int unsigned MAX_RADIUS       = 7,
  parameter int unsigned MAX_ROW_ELEMENTS = 4096,
  parameter int unsigned MAX_CHANNELS     = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [baf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [baf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [baf_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic                               frame_start_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [baf_pkg::SAMPLE_W-1:0]       average_o,
  output logic                               row_last_o,
  input  baf_pkg::cmd_t                      cmd_i,
  output baf_pkg::status_t                   status_o
);
  import baf_pkg::*;

  localparam int unsigned LINES = (MAX_RADIUS > 0) ? 2 * MAX_RADIUS : 1;
  localparam int unsigned LW    = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int unsigned CW    = $clog2(MAX_ROW_ELEMENTS);
  localparam int unsigned HIST  = 2 * MAX_RADIUS * MAX_CHANNELS + 1;
  localparam int unsigned HW    = $clog2(HIST + 1);
  localparam int unsigned SIDE_MAX = 2 * MAX_RADIUS + 1;
  localparam int unsigned VSW   = SAMPLE_W + $clog2(SIDE_MAX);
  localparam int unsigned TW    = VSW + $clog2(SIDE_MAX);
  localparam int unsigned KW    = $clog2(SIDE_MAX + 1);
  localparam int unsigned DVW   = $clog2(SIDE_MAX * SIDE_MAX + 1);
  localparam int unsigned DCW   = $clog2(TW + 1);
  localparam int unsigned EW    = 16; // common compare width

  // configuration
  logic [2:0]            radius_q;
  logic [CH_W-1:0]       channels_q;
  logic [CFG_DATA_W-1:0] row_elem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q   <= 3'd1;
      channels_q <= CH_W'(3);
      row_elem_q <= CFG_DATA_W'(3072);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIUS:   radius_q   <= cfg_data_i[2:0];
        CFG_CHANNELS: channels_q <= cfg_data_i[CH_W-1:0];
        CFG_ROW_ELEM: row_elem_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective (clamped) settings
  logic [EW-1:0] r_eff, ch_eff, len_eff, two_r, two_r_ch;
  always_comb begin
    r_eff = (EW'(radius_q) > EW'(MAX_RADIUS)) ? EW'(MAX_RADIUS) : EW'(radius_q);
    if (channels_q == '0) ch_eff = EW'(1);
    else if (EW'(channels_q) > EW'(MAX_CHANNELS)) ch_eff = EW'(MAX_CHANNELS);
    else ch_eff = EW'(channels_q);
    if (row_elem_q == '0) len_eff = EW'(1);
    else if (EW'(row_elem_q) > EW'(MAX_ROW_ELEMENTS)) len_eff = EW'(MAX_ROW_ELEMENTS);
    else len_eff = EW'(row_elem_q);
    two_r    = r_eff << 1;
    two_r_ch = EW'(two_r[7:0] * ch_eff[7:0]);
  end

  // positions
  logic [CW-1:0]        col_q, cur_col_q;
  logic [ROW_POS_W-1:0] row_q;
  logic [LW-1:0]        ws_q, ws_cur_q, slot_q;
  logic                 need_q, emit_q, last_q;
  logic [SAMPLE_W-1:0]  sample_q;

  logic [CW-1:0]        c_now;
  logic [ROW_POS_W-1:0] r_now;
  logic [LW-1:0]        w_now;
  logic                 last_now;

  function automatic logic [LW-1:0] slot_dec(input logic [LW-1:0] s);
    slot_dec = (s == '0) ? LW'(LINES - 1) : LW'(s - 1'b1);
  endfunction

  function automatic logic [LW-1:0] slot_inc(input logic [LW-1:0] s);
    slot_inc = (s == LW'(LINES - 1)) ? '0 : LW'(s + 1'b1);
  endfunction

  always_comb begin
    c_now    = frame_start_i ? '0 : col_q;
    r_now    = frame_start_i ? '0 : row_q;
    w_now    = frame_start_i ? '0 : ws_q;
    last_now = (EW'(c_now) + EW'(1)) >= len_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      ws_q  <= '0;
    end else if (cmd_i.accept) begin
      if (last_now) begin
        col_q <= '0;
        if (r_now != '1) row_q <= r_now + 1'b1;
        else row_q <= r_now;
        ws_q  <= slot_inc(w_now);
      end else begin
        col_q <= CW'(c_now + 1'b1);
        row_q <= r_now;
        ws_q  <= w_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_col_q <= c_now;
      ws_cur_q  <= w_now;
      sample_q  <= sample_i;
      need_q    <= EW'(r_now) >= two_r;
      emit_q    <= (EW'(r_now) >= two_r) && (EW'(c_now) >= two_r_ch);
      last_q    <= last_now;
    end
  end

  // step counter and accumulator
  logic [KW-1:0] k_q;
  logic [TW-1:0] acc_q;
  logic [VSW-1:0] line_word, hist_rdata;
  logic [SAMPLE_W-1:0] line_rdata;
  logic [HW-1:0] wp_q, hp_q, hp_next;

  assign line_word = VSW'(line_rdata);

  always_comb begin
    if (EW'(hp_q) >= ch_eff) hp_next = HW'(EW'(hp_q) - ch_eff);
    else hp_next = HW'(EW'(hp_q) + EW'(HIST) - ch_eff);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      k_q    <= '0;
      acc_q  <= TW'(sample_i);
      slot_q <= slot_dec(w_now);
    end else if (cmd_i.line_acc) begin
      k_q    <= k_q + 1'b1;
      acc_q  <= acc_q + TW'(line_word);
      slot_q <= slot_dec(slot_q);
    end else if (cmd_i.write) begin
      k_q   <= '0;
      acc_q <= '0;
      hp_q  <= wp_q;
    end else if (cmd_i.hist_acc) begin
      k_q   <= k_q + 1'b1;
      acc_q <= acc_q + TW'(hist_rdata);
      hp_q  <= hp_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
    end else if (cmd_i.write) begin
      wp_q <= (wp_q == HW'(HIST - 1)) ? '0 : HW'(wp_q + 1'b1);
    end
  end

  // line store: rows of the image by slot, addressed {slot, column}
  logic [LW+CW-1:0] line_addr;
  assign line_addr = cmd_i.line_rd ? {slot_q, cur_col_q} : {ws_cur_q, cur_col_q};

  baf_ram #(.WIDTH(SAMPLE_W), .DEPTH(LINES << CW)) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .addr_i  (line_addr),
    .wdata_i (sample_q),
    .rdata_o (line_rdata)
  );

  // column-sum history, circular
  baf_ram #(.WIDTH(VSW), .DEPTH(HIST)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .addr_i  (cmd_i.hist_rd ? hp_q : wp_q),
    .wdata_i (acc_q[VSW-1:0]),
    .rdata_o (hist_rdata)
  );

  // restoring divider by (2r+1)^2, one quotient bit a cycle
  logic [DVW-1:0] divisor;
  logic [DVW-1:0] rem_q;
  logic [TW-1:0]  quo_q;
  logic [DCW-1:0] dcnt_q;
  logic [DVW:0]   trial;
  logic           fits;
  logic [7:0]     side;

  always_comb begin
    side    = 8'(two_r) + 8'd1;
    divisor = DVW'(side * side);
    trial   = {rem_q, quo_q[TW-1]};
    fits    = trial >= (DVW+1)'(divisor);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hist_acc && status_o.hist_last) begin
      rem_q  <= '0;
      quo_q  <= acc_q + TW'(hist_rdata);
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= fits ? DVW'(trial - (DVW+1)'(divisor)) : trial[DVW-1:0];
      quo_q  <= {quo_q[TW-2:0], fits};
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  // output register
  logic                out_valid_q;
  logic [SAMPLE_W-1:0] average_q;
  logic                row_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      average_q  <= quo_q[SAMPLE_W-1:0];
      row_last_q <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign average_o   = average_q;
  assign row_last_o  = row_last_q;

  always_comb begin
    status_o.need_lines = need_q && (r_eff != '0);
    status_o.line_last  = EW'(k_q) == (two_r - EW'(1));
    status_o.emit       = emit_q;
    status_o.hist_last  = EW'(k_q) == two_r;
    status_o.div_last   = dcnt_q == DCW'(TW - 1);
    status_o.out_busy   = out_valid_q && !out_ready_i;
  end
endmodule

// ----- rtl/box_average_2d_filter.sv -----
// 2D box-average filter over an interleaved, already padded raster stream.
// One 8-bit word per element, rows in order, channels interleaved. For each
// complete (2r+1)x(2r+1) window of one channel the block emits
// floor(sum / (2r+1)^2), centered on the output element, when the window's
// bottom-right element arrives; row_last flags the last result of a row.
// Flow: one word at a time. A word is accepted, then takes a read and an
// accumulate step per stored row read (2r rows once 2r rows are in) or a
// skip step, then a write step; if it completes a window, also a read and
// an accumulate step per column-sum tap (2r+1 taps), the divider at one
// quotient bit per cycle (16 at the default sizes) and a load step that
// waits for the output register to free up. The line store and column-sum
// memory are single-port with registered reads, hence the separate read
// and accumulate steps. A finished result sits in an output register, so
// the next word is taken while it waits. Line store contents are undefined
// until written; no clearing pass. Config writes only when idle.
// Depends on baf_pkg, baf_in_if, baf_out_if, baf_ctrl, baf_datapath, baf_ram.
module box_average_2d_filter #(
  parameter int unsigned MAX_RADIUS       = 7,
  parameter int unsigned MAX_ROW_ELEMENTS = 4096,
  parameter int unsigned MAX_CHANNELS     = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [baf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [baf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  baf_in_if.sink                         in_i,
  baf_out_if.source                      out_o
);
  import baf_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  baf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // storage, arithmetic and output word register
  baf_datapath #(
    .MAX_RADIUS       (MAX_RADIUS),
    .MAX_ROW_ELEMENTS (MAX_ROW_ELEMENTS),
    .MAX_CHANNELS     (MAX_CHANNELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .sample_i      (in_i.sample),
    .frame_start_i (in_i.frame_start),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .average_o     (out_o.average),
    .row_last_o    (out_o.row_last),
    .cmd_i         (cmd),
    .status_o      (status)
  );
endmodule

// ----- tb/baf_checker.sv -----
`timescale 1ns / 1ps
// Checker for the 2D box-average filter: watches config writes and both word
// channels, predicts each average and compares. Depends on baf_pkg, baf_in_if, baf_out_if.
module baf_checker #(
  parameter int unsigned MAX_RADIUS       = 7,
  parameter int unsigned MAX_ROW_ELEMENTS = 4096,
  parameter int unsigned MAX_CHANNELS     = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [baf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [baf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  baf_in_if                              in_i,
  baf_out_if                             out_i,
  output int                             errors_o,
  output int                             pending_o,
  output int                             checked_o
);
  import baf_pkg::*;

  localparam int unsigned LINES = (2 * MAX_RADIUS > 0) ? 2 * MAX_RADIUS : 1;
  localparam int unsigned HIST  = 2 * MAX_RADIUS * MAX_CHANNELS + 1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic                row_last;
  } avg_word_t;

  logic [SAMPLE_W-1:0] line_mem [LINES*MAX_ROW_ELEMENTS];
  int unsigned         col_sums [HIST];
  int unsigned         radius_q, chan_q, len_q;
  int unsigned         col_pos, row_pos, slot_q;
  avg_word_t           avg_q [$];

  // box mean for one accepted word; pushes at most one expected average
  function void predict_average(input logic [SAMPLE_W-1:0] smp, input logic fs);
    int unsigned r, ch, len, col, vsum, total, side, sl;
    avg_word_t w;
    r   = (radius_q > MAX_RADIUS) ? MAX_RADIUS : radius_q;
    ch  = (chan_q == 0) ? 1 : ((chan_q > MAX_CHANNELS) ? MAX_CHANNELS : chan_q);
    len = (len_q == 0) ? 1 : ((len_q > MAX_ROW_ELEMENTS) ? MAX_ROW_ELEMENTS : len_q);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
      slot_q  = 0;
    end
    col = (col_pos >= MAX_ROW_ELEMENTS) ? MAX_ROW_ELEMENTS - 1 : col_pos;
    vsum = smp;
    if (row_pos >= 2 * r) begin
      for (int unsigned k = 1; k <= 2 * r; k++) begin
        sl = (slot_q + LINES - (k % LINES)) % LINES;
        vsum += line_mem[sl * MAX_ROW_ELEMENTS + col];
      end
    end
    line_mem[(slot_q % LINES) * MAX_ROW_ELEMENTS + col] = smp;
    for (int i = HIST - 1; i > 0; i--) col_sums[i] = col_sums[i-1];
    col_sums[0] = vsum;
    if (row_pos >= 2 * r && col >= 2 * r * ch) begin
      total = 0;
      side  = 2 * r + 1;
      for (int unsigned k = 0; k <= 2 * r; k++)
        if (k * ch < HIST) total += col_sums[k * ch];
      w.average  = SAMPLE_W'(total / (side * side));
      w.row_last = (col + 1 >= len);
      avg_q.push_back(w);
    end
    if (col + 1 >= len) begin
      col_pos = 0;
      if (row_pos < 16'hFFFF) row_pos++;
      slot_q = (slot_q + 1) % LINES;
    end else begin
      col_pos = col + 1;
    end
  endfunction

  task report_mismatch(input string what, input int exp_v, input int got_v);
    $display("%0t ns: %s mismatch, expected %0d got %0d", $time, what, exp_v, got_v);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  = 1;
      chan_q    = 3;
      len_q     = 3072;
      col_pos   = 0;
      row_pos   = 0;
      slot_q    = 0;
      foreach (col_sums[i]) col_sums[i] = 0;
      avg_q.delete();
      errors_o  = 0;
      checked_o = 0;
      pending_o = 0;
    end else begin
      avg_word_t w;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_RADIUS:   radius_q = cfg_data_i[CH_W-1:0];
          CFG_CHANNELS: chan_q   = cfg_data_i[CH_W-1:0];
          CFG_ROW_ELEM: len_q    = cfg_data_i;
          default: ;
        endcase
      end
      if (out_i.valid && out_i.ready) begin
        if (avg_q.size() == 0) begin
          report_mismatch("unexpected average", -1, out_i.average);
        end else begin
          w = avg_q.pop_front();
          checked_o++;
          if (out_i.average !== w.average)
            report_mismatch("average", w.average, out_i.average);
          if (out_i.row_last !== w.row_last)
            report_mismatch("row_last", w.row_last, out_i.row_last);
        end
      end
      if (in_i.valid && in_i.ready) predict_average(in_i.sample, in_i.frame_start);
      pending_o = avg_q.size();
    end
  end
endmodule

// ----- tb/box_average_2d_filter_tb.sv -----
`timescale 1ns / 1ps
// Top of the box-average filter bench: clock, reset, config and word stimulus.
// Depends on baf_pkg, baf_in_if, baf_out_if, baf_checker and the filter itself.
module box_average_2d_filter_tb;
  import baf_pkg::*;

  localparam int LIMIT_CYCLES = 4_000_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  baf_in_if  in_ch ();
  baf_out_if out_ch ();

  int errors, pending, checked;
  int snd_idle, rcv_idle;   // percent of cycles each side sits out
  int hold_req, hold_seen, hold_left;
  int words_sent, settings_run;
  int cycles;

  box_average_2d_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  baf_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_i      (out_ch),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    out_ch.ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  // write one register; only called with the filter idle
  task write_reg(input cfg_idx_e idx, input int unsigned val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = CFG_DATA_W'(val);
    @(negedge clk_i);
    cfg_we   = 1'b0;
  endtask

  // offer one word, with random sender gaps, until it is taken
  task send_word(input logic [SAMPLE_W-1:0] smp, input logic fs);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       = 1'b1;
    in_ch.sample      = smp;
    in_ch.frame_start = fs;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    words_sent++;
  endtask

  // let everything in flight come out; covers words that make no result
  task drain;
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task set_mode(input int m);
    case (m % 3)
      0: begin snd_idle = 25; rcv_idle = 76; end
      1: begin snd_idle = 76; rcv_idle = 25; end
      default: begin snd_idle = 0; rcv_idle = 0; end
    endcase
  endtask

  // one frame of random rows; mostly clean, rarely a stray frame start.
  // hold_at / pause_at pick word positions for the pressure events.
  task run_frame(input int r, input int ch, input int len, input int rows,
                 input int eff_len, input int hold_at, input int pause_at);
    logic [SAMPLE_W-1:0] smp;
    logic fs;
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_CHANNELS, ch);
    write_reg(CFG_ROW_ELEM, len);
    settings_run++;
    for (int i = 0; i < rows * eff_len; i++) begin
      if (i == hold_at) hold_req++;
      if (i == pause_at) begin
        // sender waits for every expected average before going on
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
      fs  = (i == 0) || ($urandom_range(0, 199) == 0);
      smp = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                        : SAMPLE_W'($urandom_range(0, 255));
      send_word(smp, fs);
    end
    drain();
  endtask

  initial begin
    cfg_we            = 1'b0;
    cfg_idx           = CFG_RADIUS;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.sample      = '0;
    in_ch.frame_start = 1'b0;
    hold_req          = 0;
    words_sent        = 0;
    settings_run      = 0;
    set_mode(0);
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: 3x3 box, 4-word rows; full-scale rows, then a zero row,
    // then a fresh frame mid-stream that must not read the old rows
    write_reg(CFG_RADIUS, 1);
    write_reg(CFG_CHANNELS, 1);
    write_reg(CFG_ROW_ELEM, 4);
    settings_run++;
    for (int i = 0; i < 12; i++) send_word(8'hFF, i == 0);
    for (int i = 0; i < 4; i++) send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    for (int i = 0; i < 8; i++) send_word(SAMPLE_W'(i * 36), i == 0);
    drain();

    // zero channels and zero row length both act as 1: every word a result
    run_frame(0, 0, 0, 30, 1, -1, -1);
    // largest box, channels above range saturate to 4
    run_frame(7, 7, 60, 15, 60, -1, -1);
    run_frame(2, 2, 20, 8, 20, 90, -1);
    set_mode(1);
    run_frame(3, 3, 30, 8, 30, -1, 150);
    run_frame(1, 4, 10, 15, 10, 60, -1);
    // row too short for the window: no averages at all
    run_frame(2, 2, 8, 5, 8, -1, -1);
    set_mode(2);
    run_frame(5, 1, 15, 12, 15, -1, -1);
    // row length above range saturates to the widest row: no row end early
    run_frame(0, 4, 8191, 1, 150, -1, -1);

    $display("Ran %0d words over %0d register settings, %0d averages compared",
             words_sent, settings_run, checked);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/baf_pkg.sv
rtl/baf_in_if.sv
rtl/baf_out_if.sv
rtl/baf_ram.sv
rtl/baf_ctrl.sv
rtl/baf_datapath.sv
rtl/box_average_2d_filter.sv
tb/baf_checker.sv
tb/box_average_2d_filter_tb.sv
